FILE: rtl/spi_slave_memory_bridge_defines.svh
// Assertion macros shared by the bridge RTL.
// Expects signals named clk and rst in the using module.
`ifndef SPI_SLAVE_MEMORY_BRIDGE_DEFINES_SVH
`define SPI_SLAVE_MEMORY_BRIDGE_DEFINES_SVH

// Same-cycle property, checked outside reset.
`define SSMB_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) \
    else $error(msg);

// Antecedent this cycle, consequent on the next cycle.
`define SSMB_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: rtl/ssmb_pkg.sv
// Shared types and constants for the SPI slave memory bridge.
// No dependencies.
package ssmb_pkg;

  localparam logic [7:0] FILL_BYTE  = 8'hFF;
  localparam logic [3:0] ADDR_BYTES = 4'd4;

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 8;

  // Register indexes on the configuration channel
  localparam logic [CFG_IDX_W-1:0] CFG_READ_OPCODE  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_WRITE_OPCODE = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_DUMMY_COUNT  = 2'd2;

  localparam logic [7:0] RESET_READ_OPCODE  = 8'h03;
  localparam logic [7:0] RESET_WRITE_OPCODE = 8'h02;
  localparam logic [3:0] RESET_DUMMY_COUNT  = 4'd4;

  typedef enum logic [6:0] {
    PH_OPCODE  = 7'b0000001,
    PH_ADDR_RD = 7'b0000010,
    PH_ADDR_WR = 7'b0000100,
    PH_DUMMY   = 7'b0001000,
    PH_RDATA   = 7'b0010000,
    PH_WDATA   = 7'b0100000,
    PH_IGNORE  = 7'b1000000
  } phase_t;

  // Memory access requested by the current item
  typedef struct packed {
    logic rd;
    logic wr;
  } mem_op_t;

endpackage

FILE: rtl/ssmb_if.sv
// Handshake channel interfaces: exchanged bytes in, returned bytes out,
// and register writes. Depends on ssmb_pkg.
interface ssmb_rx_if;
  logic       valid;
  logic       ready;
  logic       first_in_frame;
  logic [7:0] mosi_byte;

  modport source (output valid, output first_in_frame, output mosi_byte, input ready);
  modport sink   (input valid, input first_in_frame, input mosi_byte, output ready);
endinterface

interface ssmb_tx_if;
  logic       valid;
  logic       ready;
  logic [7:0] miso_byte;

  modport source (output valid, output miso_byte, input ready);
  modport sink   (input valid, input miso_byte, output ready);
endinterface

interface ssmb_cfg_if;
  logic                             valid;
  logic                             ready;
  logic [ssmb_pkg::CFG_IDX_W-1:0]   index;
  logic [ssmb_pkg::CFG_DATA_W-1:0]  data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

FILE: rtl/spi_slave_memory_bridge.sv
// Top level of the SPI slave memory bridge: sequencer, byte RAM, result stages.
// Depends on ssmb_pkg, ssmb_if, ssmb_ram, ssmb_ctrl, spi_slave_memory_bridge_defines.svh.
//
//  port | dir  | item content
//  -----+------+----------------------------------------
//  rx   | sink | first_in_frame, mosi_byte
//  tx   | src  | miso_byte
//  cfg  | sink | index (0 read_opcode, 1 write_opcode, 2 dummy_count), data
//
// One item per cycle while tx does not stall; each result passes through stage 1,
// which waits for the registered RAM read, and then through the tx output register.
// Synchronous active-high reset; RAM contents are not cleared and need no sweep.
// tx stalls back up through one data stage into rx.ready; cfg is always ready.
// MEM_BYTES must be a power of two; addresses wrap at that size.
`include "spi_slave_memory_bridge_defines.svh"

module spi_slave_memory_bridge #(
  parameter int MEM_BYTES = 4096
) (
  input  logic      clk,
  input  logic      rst,
  ssmb_rx_if.sink   rx,
  ssmb_tx_if.source tx,
  ssmb_cfg_if.sink  cfg
);

  localparam int AddrW = $clog2(MEM_BYTES);

  ssmb_pkg::mem_op_t mem_op;
  logic [AddrW-1:0]  mem_addr;
  logic [7:0]        ram_rdata;
  logic              fire;

  logic              s1_valid;
  logic              s1_rd;
  logic              s1_adv;

  assign s1_adv   = !tx.valid || tx.ready;
  assign rx.ready = !s1_valid || s1_adv;
  assign fire     = rx.valid && rx.ready;

  ssmb_ctrl #(
    .ADDR_W (AddrW)
  ) u_ctrl (
    .clk            (clk),
    .rst            (rst),
    .cfg            (cfg),
    .fire           (fire),
    .first_in_frame (rx.first_in_frame),
    .mosi_byte      (rx.mosi_byte),
    .mem_op         (mem_op),
    .mem_addr       (mem_addr)
  );

  // Reads and writes come from distinct items; a write is visible to a read
  // issued on the next cycle, so no forwarding is needed.
  ssmb_ram #(
    .WIDTH (8),
    .DEPTH (MEM_BYTES)
  ) u_ram (
    .clk   (clk),
    .en    (fire && (mem_op.rd || mem_op.wr)),
    .we    (mem_op.wr),
    .addr  (mem_addr),
    .wdata (rx.mosi_byte),
    .rdata (ram_rdata)
  );

  // Stage 1 waits for RAM data; read data holds while this stage is stalled
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (fire) begin
      s1_valid <= 1'b1;
    end else if (s1_adv) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      s1_rd <= mem_op.rd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tx.valid <= 1'b0;
    end else if (s1_adv) begin
      tx.valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv && s1_valid) begin
      tx.miso_byte <= s1_rd ? ram_rdata : ssmb_pkg::FILL_BYTE;
    end
  end

  `SSMB_ASSERT(a_op_excl, !(mem_op.rd && mem_op.wr), "read and write in one item")
  `SSMB_ASSERT_NEXT(a_fire_fills, fire, s1_valid, "accepted item missing from stage 1")
  `SSMB_ASSERT_NEXT(a_rdata_hold, s1_valid && !s1_adv, $stable(ram_rdata), "RAM data lost in stall")
  `SSMB_ASSERT_NEXT(a_read_out, s1_valid && s1_adv && s1_rd,
                    tx.valid && (tx.miso_byte == $past(ram_rdata)), "read byte not forwarded")

endmodule

FILE: rtl/ssmb_ram.sv
// Generic single-port RAM with registered read; read data holds when idle.
// No dependencies.
module ssmb_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4096
) (
  input  logic                     clk,
  input  logic                     en,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (en) begin
      if (we) begin
        mem[addr] <= wdata;
      end else begin
        rdata <= mem[addr];
      end
    end
  end

endmodule

FILE: rtl/ssmb_ctrl.sv
// Frame sequencer: configuration registers, phase, byte count and address.
// Issues at most one memory access per accepted item. Depends on ssmb_pkg, ssmb_if.
module ssmb_ctrl #(
  parameter int ADDR_W = 12
) (
  input  logic                clk,
  input  logic                rst,
  ssmb_cfg_if.sink            cfg,
  input  logic                fire,
  input  logic                first_in_frame,
  input  logic [7:0]          mosi_byte,
  output ssmb_pkg::mem_op_t   mem_op,
  output logic [ADDR_W-1:0]   mem_addr
);

  logic [7:0]        read_opcode;
  logic [7:0]        write_opcode;
  logic [3:0]        dummy_count;

  ssmb_pkg::phase_t  phase, phase_next;
  logic [3:0]        byte_count, byte_count_next;
  logic [ADDR_W-1:0] address, address_next;

  ssmb_pkg::phase_t  cur_phase;
  logic [3:0]        cur_count;
  logic [3:0]        count_inc;
  logic [ADDR_W+7:0] shifted;

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      read_opcode  <= ssmb_pkg::RESET_READ_OPCODE;
      write_opcode <= ssmb_pkg::RESET_WRITE_OPCODE;
      dummy_count  <= ssmb_pkg::RESET_DUMMY_COUNT;
    end else if (cfg.valid) begin
      case (cfg.index)
        ssmb_pkg::CFG_READ_OPCODE:  read_opcode  <= cfg.data;
        ssmb_pkg::CFG_WRITE_OPCODE: write_opcode <= cfg.data;
        ssmb_pkg::CFG_DUMMY_COUNT:  dummy_count  <= cfg.data[3:0];
        default: ;
      endcase
    end
  end

  // A frame flag restarts the sequence at the opcode
  assign cur_phase = first_in_frame ? ssmb_pkg::PH_OPCODE : phase;
  assign cur_count = first_in_frame ? 4'd0 : byte_count;
  assign count_inc = cur_count + 4'd1;
  assign shifted   = {address, mosi_byte};

  always_comb begin
    phase_next      = cur_phase;
    byte_count_next = cur_count;
    address_next    = address;
    mem_op          = '0;
    case (cur_phase)
      ssmb_pkg::PH_OPCODE: begin
        byte_count_next = 4'd0;
        address_next    = '0;
        if (mosi_byte == read_opcode) begin
          phase_next = ssmb_pkg::PH_ADDR_RD;
        end else if (mosi_byte == write_opcode) begin
          phase_next = ssmb_pkg::PH_ADDR_WR;
        end else begin
          phase_next = ssmb_pkg::PH_IGNORE;
        end
      end
      ssmb_pkg::PH_ADDR_RD, ssmb_pkg::PH_ADDR_WR: begin
        // only the low address bits index the memory
        address_next    = shifted[ADDR_W-1:0];
        byte_count_next = count_inc;
        if (count_inc >= ssmb_pkg::ADDR_BYTES) begin
          byte_count_next = 4'd0;
          if (cur_phase == ssmb_pkg::PH_ADDR_WR) begin
            phase_next = ssmb_pkg::PH_WDATA;
          end else begin
            address_next[1:0] = 2'b00;
            phase_next = (dummy_count == 4'd0) ? ssmb_pkg::PH_RDATA : ssmb_pkg::PH_DUMMY;
          end
        end
      end
      ssmb_pkg::PH_DUMMY: begin
        byte_count_next = count_inc;
        if (count_inc >= dummy_count) begin
          byte_count_next = 4'd0;
          phase_next      = ssmb_pkg::PH_RDATA;
        end
      end
      ssmb_pkg::PH_RDATA: begin
        mem_op.rd    = 1'b1;
        address_next = address + ADDR_W'(1);
      end
      ssmb_pkg::PH_WDATA: begin
        mem_op.wr    = 1'b1;
        address_next = address + ADDR_W'(1);
      end
      default: begin
        phase_next = ssmb_pkg::PH_IGNORE;
      end
    endcase
  end

  assign mem_addr = address;

  always_ff @(posedge clk) begin
    if (rst) begin
      phase      <= ssmb_pkg::PH_OPCODE;
      byte_count <= 4'd0;
      address    <= '0;
    end else if (fire) begin
      phase      <= phase_next;
      byte_count <= byte_count_next;
      address    <= address_next;
    end
  end

endmodule
